// ===== design/kvl_pkg.sv =====
// ---------------------------------------------------------------------------
// kvl_pkg: shared types and constants of the keyframe lerp sampler
// Data widths, fixed-point layout, controller states and lane result type.
// ---------------------------------------------------------------------------
package kvl_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int DIV_W        = DATA_W + FRAC_W;
  localparam int KEY_W        = 4 * DATA_W;
  localparam int SLOT_W       = 6;
  localparam int COUNT_W      = 7;
  localparam int SEG_W        = 6;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_F0   = 8'b0000_0100,
    ST_F1   = 8'b0000_1000,
    ST_F2   = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_ONE  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              clip;
  } lane_res_t;

endpackage

// ===== design/kvl_ram.sv =====
// ---------------------------------------------------------------------------
// kvl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module kvl_ram #(
  parameter int WIDTH = kvl_pkg::KEY_W,
  parameter int DEPTH = kvl_pkg::MAX_KEYS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kvl_div.sv =====
// ---------------------------------------------------------------------------
// kvl_div: bit-serial restoring divider
// Unsigned DIV_W by DATA_W division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module kvl_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [kvl_pkg::DIV_W-1:0] dividend,
  input  logic [kvl_pkg::DATA_W-1:0] divisor,
  output logic [kvl_pkg::DIV_W-1:0] quotient,
  output logic                      done
);

  localparam int DW = kvl_pkg::DIV_W;
  localparam int W  = kvl_pkg::DATA_W;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] dvd;
  logic [W-1:0]  dvs;
  logic [W-1:0]  rem;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;

  assign rem_sh   = {rem, dvd[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (run) begin
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      dvd <= {dvd[DW-2:0], ge};
    end
  end

endmodule

// ===== design/kvl_lane.sv =====
// ---------------------------------------------------------------------------
// kvl_lane: one interpolation axis
// Bit-serial shift-add factor*delta, then scale, add start and saturate.
// ---------------------------------------------------------------------------
module kvl_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [kvl_pkg::DATA_W-1:0] start_val,
  input  logic [kvl_pkg::DATA_W-1:0] end_val,
  input  logic                       go,
  input  logic [kvl_pkg::DATA_W-1:0] f_mag,
  input  logic                       f_neg,
  output kvl_pkg::lane_res_t         res,
  output logic                       done
);

  localparam int W  = kvl_pkg::DATA_W;
  localparam int F  = kvl_pkg::FRAC_W;
  localparam int CW = $clog2(W);
  localparam int SW = 2 * W - F + 1;
  localparam int RW = SW + 1;

  logic [W-1:0]   start_r;
  logic [W-1:0]   d_mag;
  logic           d_neg;
  logic           p_neg;
  logic [W-1:0]   m;
  logic [2*W-1:0] p;
  logic [CW-1:0]  cnt;
  logic           run;
  logic [W:0]     delta;
  logic [W:0]     step_sum;
  logic [SW-1:0]  scaled;
  logic [RW-1:0]  total;

  assign delta    = {end_val[W-1], end_val} - {start_val[W-1], start_val};
  assign step_sum = {1'b0, p[2*W-1:W]} + (m[0] ? {1'b0, d_mag} : '0);

  // drop the fraction toward zero on the magnitude, then apply the sign
  always_comb begin
    scaled = {1'b0, p[2*W-1:F]};
    if (p_neg) begin
      scaled = -scaled;
    end
    total = {{(RW-W){start_r[W-1]}}, start_r} + {scaled[SW-1], scaled};
    res.clip  = 1'b0;
    res.value = total[W-1:0];
    if (!total[RW-1] && (total[RW-2:W-1] != '0)) begin
      res.clip  = 1'b1;
      res.value = {1'b0, {(W-1){1'b1}}};
    end else if (total[RW-1] && (total[RW-2:W-1] != '1)) begin
      res.clip  = 1'b1;
      res.value = {1'b1, {(W-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= start_val;
      d_neg   <= delta[W];
      d_mag   <= delta[W] ? W'(-delta) : delta[W-1:0];
    end
    if (go) begin
      m     <= f_mag;
      p     <= '0;
      p_neg <= f_neg ^ d_neg;
    end else if (run) begin
      p <= {step_sum, p[W-1:1]};
      m <= m >> 1;
    end
  end

endmodule

// ===== design/keyframe_vec3_lerp_sampler.sv =====
// ---------------------------------------------------------------------------
// keyframe_vec3_lerp_sampler: keyframe table with linear vec3 sampling
// Stores time/x/y/z keys and linearly interpolates a vector at a given time.
// ---------------------------------------------------------------------------
// Items are taken one at a time: a transfer happens when start is high and
// busy is low. A key write (operation 0) lands in the table on the transfer
// edge and gives no result; busy stays low. A sample (operation 1) raises
// busy until its single result is shown on done for exactly one cycle; the
// receiver cannot stall it, so capture the result ports whenever done is
// high. With one key in use the sample goes through ST_ONE, which shows key
// 0 as read from the RAM. Otherwise the block scans the key table one key
// per cycle through the RAM read port and fetches the two segment keys in
// ST_F0, ST_F1 and ST_F2. It then runs the bit-serial divider (48 quotient
// bits, one per cycle), and after it the three bit-serial multiply lanes
// side by side (32 product bits). A zero-length segment skips the arithmetic.
// key_count is written through cfg_write/cfg_data; the user must write it
// only while idle, as the block itself does not enforce this. 0 acts as 1
// and values above MAX_KEYS act as MAX_KEYS. Table entries never written
// read back as junk.
// ---------------------------------------------------------------------------
module keyframe_vec3_lerp_sampler #(
  parameter int MAX_KEYS = kvl_pkg::MAX_KEYS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [kvl_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [kvl_pkg::SLOT_W-1:0]   key_slot,
  input  logic [kvl_pkg::DATA_W-1:0]   key_time,
  input  logic signed [kvl_pkg::DATA_W-1:0] key_x,
  input  logic signed [kvl_pkg::DATA_W-1:0] key_y,
  input  logic signed [kvl_pkg::DATA_W-1:0] key_z,
  input  logic [kvl_pkg::DATA_W-1:0]   sample_time,
  output logic                         done,
  output logic signed [kvl_pkg::DATA_W-1:0] out_x,
  output logic signed [kvl_pkg::DATA_W-1:0] out_y,
  output logic signed [kvl_pkg::DATA_W-1:0] out_z,
  output logic [kvl_pkg::SEG_W-1:0]    segment,
  output logic                         zero_span,
  output logic                         clipped
);

  localparam int W    = kvl_pkg::DATA_W;
  localparam int F    = kvl_pkg::FRAC_W;
  localparam int DW   = kvl_pkg::DIV_W;
  localparam int AW   = $clog2(MAX_KEYS);
  localparam int NW0  = $clog2(MAX_KEYS + 1);
  localparam int CW   = (NW0 > kvl_pkg::COUNT_W) ? NW0 : kvl_pkg::COUNT_W;

  kvl_pkg::state_t state, state_next;

  logic [kvl_pkg::COUNT_W-1:0] key_count;
  logic [CW-1:0]               kc_ext;
  logic [CW-1:0]               n_eff;
  logic [CW-1:0]               j;
  logic [CW-1:0]               j_inc;
  logic [AW-1:0]               seg;
  logic [AW-1:0]               seg_inc;
  logic [AW-1:0]               raddr;
  logic [kvl_pkg::KEY_W-1:0]   rdata;
  logic                        accept;
  logic                        wr_en;
  logic [W-1:0]                t_r;
  logic [W-1:0]                t0_r;
  logic [W-1:0]                sx, sy, sz;
  logic [W-1:0]                t1;
  logic [W:0]                  num, den;
  logic                        neg_r;
  logic                        clip_f;
  logic                        div_go;
  logic                        div_done;
  logic [DW-1:0]               quot;
  logic [W-1:0]                f_mag;
  logic                        f_sat;
  logic                        lane_load;
  logic                        lane_go;
  logic                        dx, dy, dz;
  kvl_pkg::lane_res_t          rx, ry, rz;

  assign accept  = start && !busy;
  assign busy    = !state[0];
  assign wr_en   = accept && (operation == kvl_pkg::OP_WRITE) &&
                   (int'(key_slot) < MAX_KEYS);
  assign kc_ext  = CW'(key_count);
  assign n_eff   = (kc_ext == '0) ? CW'(1) :
                   (kc_ext > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : kc_ext;
  assign j_inc   = j + CW'(1);
  assign seg_inc = seg + AW'(1);
  assign t1      = rdata[4*W-1:3*W];
  assign num     = {1'b0, t_r} - {1'b0, t0_r};
  assign den     = {1'b0, t1} - {1'b0, t0_r};

  // pick the table row to read next cycle
  always_comb begin
    case (state)
      kvl_pkg::ST_IDLE: raddr = (n_eff == CW'(1)) ? '0 : AW'(1);
      kvl_pkg::ST_SCAN: raddr = j_inc[AW-1:0];
      kvl_pkg::ST_F0:   raddr = seg;
      kvl_pkg::ST_F1:   raddr = seg_inc;
      default:          raddr = seg;
    endcase
  end

  kvl_ram #(
    .WIDTH(kvl_pkg::KEY_W),
    .DEPTH(MAX_KEYS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(key_slot)),
    .wdata({key_time, key_x, key_y, key_z}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // divide |t - t0| << 16 by |t1 - t0|
  kvl_div u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .dividend({(num[W] ? W'(-num) : num[W-1:0]), F'(0)}),
    .divisor (den[W] ? W'(-den) : den[W-1:0]),
    .quotient(quot),
    .done    (div_done)
  );

  // saturate the factor magnitude: +2^31-1 or -2^31
  always_comb begin
    f_mag = quot[W-1:0];
    f_sat = 1'b0;
    if (!neg_r && (quot[DW-1:W-1] != '0)) begin
      f_mag = {1'b0, {(W-1){1'b1}}};
      f_sat = 1'b1;
    end else if (neg_r && ((quot[DW-1:W] != '0) ||
                           (quot[W-1] && (quot[W-2:0] != '0)))) begin
      f_mag = {1'b1, {(W-1){1'b0}}};
      f_sat = 1'b1;
    end
  end

  assign div_go    = (state == kvl_pkg::ST_F2) && (t1 != t0_r);
  assign lane_load = (state == kvl_pkg::ST_F2);
  assign lane_go   = (state == kvl_pkg::ST_DIV) && div_done;

  kvl_lane u_lane_x (
    .clk(clk), .rst(rst), .load(lane_load), .start_val(sx),
    .end_val(rdata[3*W-1:2*W]), .go(lane_go), .f_mag(f_mag), .f_neg(neg_r),
    .res(rx), .done(dx)
  );

  kvl_lane u_lane_y (
    .clk(clk), .rst(rst), .load(lane_load), .start_val(sy),
    .end_val(rdata[2*W-1:W]), .go(lane_go), .f_mag(f_mag), .f_neg(neg_r),
    .res(ry), .done(dy)
  );

  kvl_lane u_lane_z (
    .clk(clk), .rst(rst), .load(lane_load), .start_val(sz),
    .end_val(rdata[W-1:0]), .go(lane_go), .f_mag(f_mag), .f_neg(neg_r),
    .res(rz), .done(dz)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      kvl_pkg::ST_IDLE: begin
        if (accept && (operation == kvl_pkg::OP_SAMPLE)) begin
          state_next = (n_eff == CW'(1)) ? kvl_pkg::ST_ONE : kvl_pkg::ST_SCAN;
        end
      end
      kvl_pkg::ST_SCAN: begin
        if ((t_r < t1) || (j_inc == n_eff)) begin
          state_next = kvl_pkg::ST_F0;
        end
      end
      kvl_pkg::ST_F0:  state_next = kvl_pkg::ST_F1;
      kvl_pkg::ST_F1:  state_next = kvl_pkg::ST_F2;
      kvl_pkg::ST_F2:  state_next = (t1 == t0_r) ? kvl_pkg::ST_IDLE : kvl_pkg::ST_DIV;
      kvl_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = kvl_pkg::ST_MUL;
        end
      end
      kvl_pkg::ST_MUL: begin
        if (dx && dy && dz) begin
          state_next = kvl_pkg::ST_IDLE;
        end
      end
      kvl_pkg::ST_ONE: state_next = kvl_pkg::ST_IDLE;
      default:         state_next = kvl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kvl_pkg::ST_IDLE;
      key_count <= kvl_pkg::COUNT_W'(1);
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_write) begin
        key_count <= cfg_data;
      end
      if ((state == kvl_pkg::ST_ONE) ||
          ((state == kvl_pkg::ST_F2) && (t1 == t0_r)) ||
          ((state == kvl_pkg::ST_MUL) && dx && dy && dz)) begin
        done <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      kvl_pkg::ST_IDLE: begin
        if (accept) begin
          t_r <= sample_time;
          j   <= CW'(1);
          seg <= '0;
        end
      end
      kvl_pkg::ST_SCAN: begin
        // first key whose time exceeds the sample closes the segment
        if (t_r < t1) begin
          seg <= AW'(j - CW'(1));
        end else if (j_inc == n_eff) begin
          seg <= '0;
        end
        j <= j_inc;
      end
      kvl_pkg::ST_F1: begin
        t0_r <= t1;
        sx   <= rdata[3*W-1:2*W];
        sy   <= rdata[2*W-1:W];
        sz   <= rdata[W-1:0];
      end
      kvl_pkg::ST_F2: begin
        neg_r <= num[W] ^ den[W];
        if (t1 == t0_r) begin
          out_x     <= sx;
          out_y     <= sy;
          out_z     <= sz;
          segment   <= kvl_pkg::SEG_W'(seg);
          zero_span <= 1'b1;
          clipped   <= 1'b0;
        end
      end
      kvl_pkg::ST_DIV: begin
        if (div_done) begin
          clip_f <= f_sat;
        end
      end
      kvl_pkg::ST_MUL: begin
        out_x     <= rx.value;
        out_y     <= ry.value;
        out_z     <= rz.value;
        segment   <= kvl_pkg::SEG_W'(seg);
        zero_span <= 1'b0;
        clipped   <= clip_f | rx.clip | ry.clip | rz.clip;
      end
      kvl_pkg::ST_ONE: begin
        out_x     <= rdata[3*W-1:2*W];
        out_y     <= rdata[2*W-1:W];
        out_z     <= rdata[W-1:0];
        segment   <= '0;
        zero_span <= 1'b0;
        clipped   <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // a result always appears as the sequencer returns to idle
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("sample finished without a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == kvl_pkg::ST_IDLE))
    else $error("result shown while still working");

  a_zero_noclip: assert property (@(posedge clk) disable iff (rst)
    (done && zero_span) |-> !clipped)
    else $error("zero-length segment flagged as clipped");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == kvl_pkg::ST_DIV))
    else $error("divider finished outside its state");

  a_lane_sync: assert property (@(posedge clk) disable iff (rst)
    dx |-> (dy && dz && (state == kvl_pkg::ST_MUL)))
    else $error("multiply lanes out of step");

endmodule
